// ----- design/imsu_pkg.sv -----
package imsu_pkg;

   // Lattice geometry
   localparam int LATTICE_SIDE = 32;
   localparam int SITES        = LATTICE_SIDE * LATTICE_SIDE;
   localparam int IDX_W        = $clog2(LATTICE_SIDE);
   localparam int FIELD_RANGE  = 32;   // reach of the 5-bit site fields

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LATTICE_SIDE - 1);

   // Reset values of coupling and field, Q8.8
   localparam int RESET_J = 256;
   localparam int RESET_H = 256;

   // Running totals
   localparam int MAG_W    = 12;
   localparam int ENERGY_W = 40;
   localparam int DE_W     = 20;

   localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);
   localparam logic signed [ENERGY_W-1:0] ENERGY_RESET =
      ENERGY_W'(-(2 * RESET_J + RESET_H) * SITES);
   localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
   localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_TRIAL = 1'b1;

   // Register map, 8-byte spacing
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam logic [2:0] REG_COUPLING_J = 3'd0;
   localparam logic [2:0] REG_FIELD_H    = 3'd1;
   localparam logic [2:0] REG_TAB_LOW    = 3'd2;
   localparam logic [2:0] REG_TAB_MID    = 3'd3;
   localparam logic [2:0] REG_TAB_HIGH   = 3'd4;

   typedef struct packed {
      logic signed [15:0] coupling_j;
      logic signed [15:0] field_h;
      logic [63:0]        tab_low;
      logic [63:0]        tab_mid;
      logic [31:0]        tab_high;
   } cfg_type;

   typedef struct packed {
      logic        req_type;
      logic [4:0]  site_row;
      logic [4:0]  site_col;
      logic        load_spin_up;
      logic [15:0] random_fraction;
   } req_beat_type;

   typedef struct packed {
      logic                       flip_taken;
      logic                       spin_now;
      logic signed [MAG_W-1:0]    magnetization_now;
      logic signed [ENERGY_W-1:0] energy_now;
      logic signed [DE_W-1:0]     energy_change;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_CTR,
      S_RD_UP,
      S_RD_DN,
      S_CALC,
      S_MUL,
      S_DE,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_CLEAR,
      STEP_LATCH,
      STEP_RD_CTR,
      STEP_RD_UP,
      STEP_RD_DN,
      STEP_CALC,
      STEP_MUL,
      STEP_DE,
      STEP_COMMIT
   } step_type;

   typedef struct packed {
      step_type         step;
      logic [IDX_W-1:0] clear_row;
   } cmd_type;

   // Site fields wrapped onto the lattice, worked out at elaboration
   typedef logic [FIELD_RANGE-1:0][IDX_W-1:0] wrap_tab_type;

   function automatic wrap_tab_type build_wrap_tab();
      wrap_tab_type t;
      for (int i = 0; i < FIELD_RANGE; i++) begin
         t[i] = IDX_W'(i % LATTICE_SIDE);
      end
      return t;
   endfunction

   localparam wrap_tab_type SITE_WRAP = build_wrap_tab();

endpackage

// ----- design/imsu_req_if.sv -----
interface imsu_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [4:0]  site_row;
   logic [4:0]  site_col;
   logic        load_spin_up;
   logic [15:0] random_fraction;

   modport source (output valid, req_type, site_row, site_col, load_spin_up,
                   random_fraction, input ready);
   modport sink   (input valid, req_type, site_row, site_col, load_spin_up,
                   random_fraction, output ready);
endinterface

// ----- design/imsu_rsp_if.sv -----
interface imsu_rsp_if;
   logic               valid;
   logic               ready;
   logic               flip_taken;
   logic               spin_now;
   logic signed [11:0] magnetization_now;
   logic signed [39:0] energy_now;
   logic signed [19:0] energy_change;

   modport source (output valid, flip_taken, spin_now, magnetization_now, energy_now,
                   energy_change, input ready);
   modport sink   (input valid, flip_taken, spin_now, magnetization_now, energy_now,
                   energy_change, output ready);
endinterface

// ----- design/imsu_csr.sv -----
module imsu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [imsu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [imsu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [imsu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output imsu_pkg::cfg_type                   cfg
);
   import imsu_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode; unmapped indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_COUPLING_J: cfg_in.coupling_j = csr_pwdata[15:0];
            REG_FIELD_H:    cfg_in.field_h    = csr_pwdata[15:0];
            REG_TAB_LOW:    cfg_in.tab_low    = csr_pwdata;
            REG_TAB_MID:    cfg_in.tab_mid    = csr_pwdata;
            REG_TAB_HIGH:   cfg_in.tab_high   = csr_pwdata[31:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coupling_j <= 16'(RESET_J);
         cfg_ff.field_h    <= 16'(RESET_H);
         cfg_ff.tab_low    <= '0;
         cfg_ff.tab_mid    <= '0;
         cfg_ff.tab_high   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back
   always_comb begin
      unique case (reg_idx)
         REG_COUPLING_J: csr_prdata = CSR_DATA_W'(cfg_ff.coupling_j);
         REG_FIELD_H:    csr_prdata = CSR_DATA_W'(cfg_ff.field_h);
         REG_TAB_LOW:    csr_prdata = cfg_ff.tab_low;
         REG_TAB_MID:    csr_prdata = cfg_ff.tab_mid;
         REG_TAB_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.tab_high);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ----- design/imsu_ctrl.sv -----
module imsu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output imsu_pkg::cmd_type cmd
);
   import imsu_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [IDX_W-1:0] clr_cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             req_fire;
   logic             out_free;

   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer: clearing pass, then one item at a time
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      req_ready     = 1'b0;
      cmd.step      = STEP_NONE;
      cmd.clear_row = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.step = STEP_CLEAR;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = STEP_LATCH;
               state_in = S_RD_CTR;
            end
         end
         S_RD_CTR: begin
            cmd.step = STEP_RD_CTR;
            state_in = S_RD_UP;
         end
         S_RD_UP: begin
            cmd.step = STEP_RD_UP;
            state_in = S_RD_DN;
         end
         S_RD_DN: begin
            cmd.step = STEP_RD_DN;
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.step = STEP_CALC;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.step = STEP_MUL;
            state_in = S_DE;
         end
         S_DE: begin
            cmd.step = STEP_DE;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the beat
            if (out_free) begin
               cmd.step = STEP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output beat valid: set on commit, dropped when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step == STEP_COMMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result beat raised without a commit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("commit while output beat still pending");

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_RD_CTR)
      else $error("accepted item did not start the lattice read");

endmodule

// ----- design/imsu_datapath.sv -----
module imsu_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  imsu_pkg::cmd_type      cmd,
   input  imsu_pkg::cfg_type      cfg,
   input  imsu_pkg::req_beat_type req,
   output imsu_pkg::rsp_beat_type rsp
);
   import imsu_pkg::*;

   // Lattice store, one row per word
   logic [LATTICE_SIDE-1:0] lattice_mem [LATTICE_SIDE];
   logic [LATTICE_SIDE-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [LATTICE_SIDE-1:0] wr_data;
   logic [LATTICE_SIDE-1:0] flipped_row;

   // Item fields
   logic             type_ff;
   logic [IDX_W-1:0] row_ff;
   logic [IDX_W-1:0] col_ff;
   logic             want_ff;
   logic [15:0]      rnd_ff;
   logic [IDX_W-1:0] row_m;
   logic [IDX_W-1:0] row_p;
   logic [IDX_W-1:0] col_m;
   logic [IDX_W-1:0] col_p;

   // Working values
   logic [LATTICE_SIDE-1:0] row_word_ff;
   logic                    old_ff;
   logic                    left_ff;
   logic                    right_ff;
   logic                    up_ff;
   logic [2:0]              ups_ff;
   logic [2:0]              ups_in;
   logic signed [4:0]       nsum;
   logic signed [DE_W-1:0]  prod_ff;
   logic signed [DE_W-1:0]  prod_in;
   logic signed [DE_W-1:0]  local_field;
   logic signed [DE_W-1:0]  de_ff;
   logic signed [DE_W-1:0]  de_in;
   logic [15:0]             thresh_ff;
   logic [3:0]              tab_code;

   // Totals and result
   logic signed [MAG_W-1:0]    mag_ff;
   logic signed [MAG_W-1:0]    mag_next;
   logic signed [ENERGY_W-1:0] energy_ff;
   logic signed [ENERGY_W-1:0] energy_next;
   logic signed [ENERGY_W:0]   energy_sum;
   logic signed [ENERGY_W-1:0] energy_sat;
   logic                       trial;
   logic                       flip;
   logic signed [DE_W-1:0]     reported;
   rsp_beat_type               out_ff;

   function automatic logic [15:0] threshold_of(input cfg_type c, input logic [3:0] code);
      logic [15:0] t;
      unique case (code)
         4'd0:    t = c.tab_low[15:0];
         4'd1:    t = c.tab_low[31:16];
         4'd2:    t = c.tab_low[47:32];
         4'd3:    t = c.tab_low[63:48];
         4'd4:    t = c.tab_mid[15:0];
         4'd5:    t = c.tab_mid[31:16];
         4'd6:    t = c.tab_mid[47:32];
         4'd7:    t = c.tab_mid[63:48];
         4'd8:    t = c.tab_high[15:0];
         4'd9:    t = c.tab_high[31:16];
         default: t = '0;
      endcase
      return t;
   endfunction

   // Periodic neighbours
   assign row_m = (row_ff == '0)       ? LAST_IDX : row_ff - IDX_W'(1);
   assign row_p = (row_ff == LAST_IDX) ? '0       : row_ff + IDX_W'(1);
   assign col_m = (col_ff == '0)       ? LAST_IDX : col_ff - IDX_W'(1);
   assign col_p = (col_ff == LAST_IDX) ? '0       : col_ff + IDX_W'(1);

   // Row read select
   always_comb begin
      unique case (cmd.step)
         STEP_RD_UP: rd_addr = row_m;
         STEP_RD_DN: rd_addr = row_p;
         default:    rd_addr = row_ff;
      endcase
   end

   // Row write: clearing pass or a taken flip
   always_comb begin
      flipped_row         = row_word_ff;
      flipped_row[col_ff] = ~old_ff;
      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = flipped_row;
      if (cmd.step == STEP_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = cmd.clear_row;
         wr_data = '1;
      end else if (cmd.step == STEP_COMMIT) begin
         wr_en = flip;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lattice_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= lattice_mem[rd_addr];
   end

   // Neighbour count and energy change
   assign ups_in      = 3'(left_ff) + 3'(right_ff) + 3'(up_ff) + 3'(rd_data_ff[col_ff]);
   assign nsum        = $signed({1'b0, ups_ff, 1'b0}) - 5'sd4;
   assign prod_in     = DE_W'(cfg.coupling_j) * DE_W'(nsum);
   assign local_field = prod_ff + DE_W'(cfg.field_h);
   assign de_in       = old_ff ? (local_field <<< 1) : -(local_field <<< 1);
   assign tab_code    = old_ff ? 4'(ups_ff) + 4'd5 : 4'(ups_ff);

   always_ff @(posedge clock) begin
      unique case (cmd.step)
         STEP_LATCH: begin
            type_ff <= req.req_type;
            row_ff  <= SITE_WRAP[req.site_row];
            col_ff  <= SITE_WRAP[req.site_col];
            want_ff <= req.load_spin_up;
            rnd_ff  <= req.random_fraction;
         end
         STEP_RD_UP: begin
            row_word_ff <= rd_data_ff;
            old_ff      <= rd_data_ff[col_ff];
            left_ff     <= rd_data_ff[col_m];
            right_ff    <= rd_data_ff[col_p];
         end
         STEP_RD_DN: up_ff   <= rd_data_ff[col_ff];
         STEP_CALC:  ups_ff  <= ups_in;
         STEP_MUL:   prod_ff <= prod_in;
         STEP_DE: begin
            de_ff     <= de_in;
            thresh_ff <= threshold_of(cfg, tab_code);
         end
         default: ;
      endcase
   end

   // Acceptance decision
   assign trial    = (type_ff == REQ_TRIAL);
   assign flip     = trial ? ((de_ff <= 0) || (rnd_ff < thresh_ff)) : (want_ff != old_ff);
   assign reported = (!trial && !flip) ? '0 : de_ff;

   // Totals with saturation on the energy
   assign energy_sum = {energy_ff[ENERGY_W-1], energy_ff} + (ENERGY_W+1)'(de_ff);
   always_comb begin
      if (energy_sum[ENERGY_W] != energy_sum[ENERGY_W-1]) begin
         energy_sat = energy_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
      end else begin
         energy_sat = energy_sum[ENERGY_W-1:0];
      end
   end
   assign energy_next = flip ? energy_sat : energy_ff;
   assign mag_next    = !flip ? mag_ff : (old_ff ? mag_ff - MAG_W'(2) : mag_ff + MAG_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff    <= MAG_RESET;
         energy_ff <= ENERGY_RESET;
      end else if (cmd.step == STEP_COMMIT) begin
         mag_ff    <= mag_next;
         energy_ff <= energy_next;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.step == STEP_COMMIT) begin
         out_ff.flip_taken        <= flip;
         out_ff.spin_now          <= old_ff ^ flip;
         out_ff.magnetization_now <= mag_next;
         out_ff.energy_now        <= energy_next;
         out_ff.energy_change     <= reported;
      end
   end

   assign rsp = out_ff;

   a_mag_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.step != STEP_COMMIT |=> $stable(mag_ff))
      else $error("magnetization moved outside a commit");

   a_energy_held_on_reject: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_COMMIT) && !flip |=> $stable(energy_ff) && $stable(mag_ff))
      else $error("totals changed on an item without a flip");

   a_spin_consistent: assert property (@(posedge clock) disable iff (reset)
      cmd.step == STEP_COMMIT |=> out_ff.spin_now == ($past(old_ff) ^ out_ff.flip_taken))
      else $error("reported spin disagrees with old spin and flip");

endmodule

// ----- design/ising_metropolis_spin_update_top.sv -----
// Flow: one item at a time; a new input beat is taken only after the last result
//   is committed, and the commit waits while the output beat is pending. Each item takes three row
//   reads through the one read port of the lattice row memory and the count, multiply and decide stages.
// Reset: synchronous, active high; after release a clearing pass writes every row
//   of the lattice to all spins up, no input beat is taken meanwhile,
//   configuration writes are taken throughout.
module ising_metropolis_spin_update_top (
   input  logic                            clock,
   input  logic                            reset,
   imsu_req_if.sink                        req_if,
   imsu_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [imsu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [imsu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [imsu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import imsu_pkg::*;

   cfg_type      cfg;
   cmd_type      cmd;
   req_beat_type req_beat;
   rsp_beat_type rsp_beat;

   // Input beat into one word
   assign req_beat.req_type        = req_if.req_type;
   assign req_beat.site_row        = req_if.site_row;
   assign req_beat.site_col        = req_if.site_col;
   assign req_beat.load_spin_up    = req_if.load_spin_up;
   assign req_beat.random_fraction = req_if.random_fraction;

   imsu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   imsu_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cfg   (cfg),
      .req   (req_beat),
      .rsp   (rsp_beat)
   );

   // Result beat out
   assign rsp_if.flip_taken        = rsp_beat.flip_taken;
   assign rsp_if.spin_now          = rsp_beat.spin_now;
   assign rsp_if.magnetization_now = rsp_beat.magnetization_now;
   assign rsp_if.energy_now        = rsp_beat.energy_now;
   assign rsp_if.energy_change     = rsp_beat.energy_change;

endmodule

// ----- tb/ising_metropolis_spin_update_top_test.sv -----
module ising_metropolis_spin_update_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import imsu_pkg::*;

   localparam int RUN_LIMIT = 600000;
   localparam int MAX_REPORTS = 50;
   // index past the last register, writes there must be dropped
   localparam logic [2:0] REG_UNUSED = 3'd5;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   imsu_req_if req_if ();
   imsu_rsp_if rsp_if ();

   ising_metropolis_spin_update_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Predicted lattice, totals and registers
   logic         lattice [LATTICE_SIDE][LATTICE_SIDE];
   int           mag_total;
   longint       energy_total;
   cfg_type      cfg_now;
   rsp_beat_type pending_spin_results[$];
   rsp_beat_type spin_want;

   int errors = 0;
   int cycle_count = 0;

   // Sender burst state
   bit tx_gaps_on = 1'b1;
   int tx_burst_left = 0;

   // Receiver stall state
   int rx_mode = 0;
   int rx_stall_left = 0;
   int rx_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
   endtask

   // One Metropolis step (or spin load) on the predicted lattice
   function automatic rsp_beat_type metropolis_step(input req_beat_type b);
      int          r, c, ups, s, de, shown, k;
      logic [15:0] thr;
      logic        old_up, flip;
      longint      e;
      rsp_beat_type o;
      r = int'(b.site_row) % LATTICE_SIDE;
      c = int'(b.site_col) % LATTICE_SIDE;
      old_up = lattice[r][c];
      ups = int'(lattice[(r + LATTICE_SIDE - 1) % LATTICE_SIDE][c])
          + int'(lattice[(r + 1) % LATTICE_SIDE][c])
          + int'(lattice[r][(c + LATTICE_SIDE - 1) % LATTICE_SIDE])
          + int'(lattice[r][(c + 1) % LATTICE_SIDE]);
      s = old_up ? 1 : -1;
      de = 2 * s * (int'($signed(cfg_now.coupling_j)) * (2 * ups - 4)
                    + int'($signed(cfg_now.field_h)));
      // threshold slot: 5 * old spin + up neighbours
      k = 5 * int'(old_up) + ups;
      if (k < 4)
         thr = cfg_now.tab_low[16*k +: 16];
      else if (k < 8)
         thr = cfg_now.tab_mid[16*(k-4) +: 16];
      else
         thr = cfg_now.tab_high[16*(k-8) +: 16];
      shown = de;
      if (b.req_type == REQ_TRIAL) begin
         flip = (de <= 0) || (b.random_fraction < thr);
      end else begin
         flip = (b.load_spin_up != old_up);
         if (!flip) shown = 0;
      end
      if (flip) begin
         lattice[r][c] = ~old_up;
         mag_total -= 2 * s;
         e = energy_total + longint'(de);
         if (e > longint'(ENERGY_MAX)) e = longint'(ENERGY_MAX);
         if (e < longint'(ENERGY_MIN)) e = longint'(ENERGY_MIN);
         energy_total = e;
      end
      o.flip_taken        = flip;
      o.spin_now          = lattice[r][c];
      o.magnetization_now = MAG_W'(mag_total);
      o.energy_now        = ENERGY_W'(energy_total);
      o.energy_change     = DE_W'(shown);
      return o;
   endfunction

   // Send one request beat, bursts separated by random gaps
   task automatic send_item(input logic kind, input logic [4:0] row, input logic [4:0] col,
                            input logic spin_up, input logic [15:0] fraction);
      req_beat_type beat;
      int gap;
      beat.req_type        = kind;
      beat.site_row        = row;
      beat.site_col        = col;
      beat.load_spin_up    = spin_up;
      beat.random_fraction = fraction;
      if (tx_gaps_on && tx_burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         tx_burst_left = $urandom_range(1, 16);
      end
      if (tx_burst_left > 0) tx_burst_left--;
      @(negedge clock);
      req_if.req_type        = beat.req_type;
      req_if.site_row        = beat.site_row;
      req_if.site_col        = beat.site_col;
      req_if.load_spin_up    = beat.load_spin_up;
      req_if.random_fraction = beat.random_fraction;
      req_if.valid           = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pending_spin_results.push_back(metropolis_step(beat));
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_spin_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_COUPLING_J: cfg_now.coupling_j = value[15:0];
         REG_FIELD_H:    cfg_now.field_h    = value[15:0];
         REG_TAB_LOW:    cfg_now.tab_low    = value;
         REG_TAB_MID:    cfg_now.tab_mid    = value;
         REG_TAB_HIGH:   cfg_now.tab_high   = value[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Read a register back and compare the bits it implements
   task automatic read_check(input logic [2:0] idx);
      logic [63:0] want, mask;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 3'b000};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_COUPLING_J: begin
            want = {48'b0, cfg_now.coupling_j};
            mask = 64'hFFFF;
         end
         REG_FIELD_H: begin
            want = {48'b0, cfg_now.field_h};
            mask = 64'hFFFF;
         end
         REG_TAB_LOW: begin
            want = cfg_now.tab_low;
            mask = '1;
         end
         REG_TAB_MID: begin
            want = cfg_now.tab_mid;
            mask = '1;
         end
         default: begin
            want = {32'b0, cfg_now.tab_high};
            mask = 64'hFFFF_FFFF;
         end
      endcase
      if ((csr_prdata & mask) !== want) report_mismatch("register readback", want, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [15:0] pick_q88();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 2048)) - 16'd1024;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_table();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Lattice straight out of reset: all up, zero thresholds, so trials are refused
   task automatic test_reset_lattice();
      send_item(REQ_TRIAL, 5'd0, 5'd0, 1'b0, 16'h0000);
      send_item(REQ_TRIAL, 5'd31, 5'd31, 1'b1, 16'hFFFF);
   endtask

   // Loads with new and same spins, neighbours across the wrap
   task automatic test_spin_loads();
      send_item(REQ_LOAD, 5'd31, 5'd31, 1'b0, 16'h1234);
      send_item(REQ_LOAD, 5'd31, 5'd31, 1'b0, 16'h0000);
      send_item(REQ_LOAD, 5'd0, 5'd0, 1'b1, 16'hFFFF);
      send_item(REQ_LOAD, 5'd0, 5'd0, 1'b0, 16'h8000);
      send_item(REQ_TRIAL, 5'd0, 5'd31, 1'b1, 16'h0000);
      // down site among up neighbours: negative change, always taken
      send_item(REQ_TRIAL, 5'd31, 5'd31, 1'b0, 16'hFFFF);
      send_item(REQ_LOAD, 5'd0, 5'd0, 1'b1, 16'h0001);
   endtask

   // Compare against a full-scale threshold: strictly below is taken
   task automatic test_acceptance_threshold();
      drain_results();
      write_reg(REG_TAB_LOW, '1);
      write_reg(REG_TAB_MID, '1);
      write_reg(REG_TAB_HIGH, 64'hFFFF_FFFF);
      send_item(REQ_TRIAL, 5'd10, 5'd10, 1'b0, 16'hFFFF);
      send_item(REQ_TRIAL, 5'd10, 5'd10, 1'b0, 16'hFFFE);
      send_item(REQ_TRIAL, 5'd10, 5'd10, 1'b1, 16'hFFFF);
   endtask

   // Zero and full-scale coupling and field of both signs
   task automatic test_coupling_extremes();
      logic [15:0] j_set [3];
      logic [15:0] h_set [3];
      j_set = '{16'h0000, 16'h8000, 16'h7FFF};
      h_set = '{16'h0000, 16'h7FFF, 16'h8000};
      for (int i = 0; i < 3; i++) begin
         drain_results();
         write_reg(REG_COUPLING_J, {48'b0, j_set[i]});
         write_reg(REG_FIELD_H, {48'b0, h_set[i]});
         if (i == 0) write_reg(REG_TAB_HIGH, 64'h0);
         send_item(REQ_TRIAL, 5'd5, 5'd5, 1'b0, 16'h0000);
         send_item(REQ_TRIAL, 5'd5, 5'd6, 1'b1, 16'hFFFF);
         send_item(REQ_LOAD, 5'd20, 5'd20, ~lattice[20][20], 16'h5555);
      end
   endtask

   // Write and read back every register, a write past the map changes nothing
   task automatic test_register_access();
      drain_results();
      write_reg(REG_COUPLING_J, {$urandom, $urandom});
      write_reg(REG_FIELD_H, {$urandom, $urandom});
      write_reg(REG_TAB_LOW, {$urandom, $urandom});
      write_reg(REG_TAB_MID, {$urandom, $urandom});
      write_reg(REG_TAB_HIGH, {32'b0, $urandom});
      write_reg(REG_UNUSED, '1);
      read_check(REG_COUPLING_J);
      read_check(REG_FIELD_H);
      read_check(REG_TAB_LOW);
      read_check(REG_TAB_MID);
      read_check(REG_TAB_HIGH);
   endtask

   // Random trials and loads over several register settings
   task automatic test_random_trials();
      int         base_r, base_c;
      bit         clustered;
      logic [4:0] row, col;
      logic       kind;
      for (int phase = 0; phase < 5; phase++) begin
         drain_results();
         write_reg(REG_COUPLING_J, {48'b0, pick_q88()});
         write_reg(REG_FIELD_H, {48'b0, pick_q88()});
         write_reg(REG_TAB_LOW, pick_table());
         write_reg(REG_TAB_MID, pick_table());
         write_reg(REG_TAB_HIGH, {32'b0, 32'(pick_table())});
         // one phase runs back to back
         tx_gaps_on = (phase != 1);
         tx_burst_left = 0;
         base_r = 0;
         base_c = 0;
         clustered = 1'b0;
         for (int n = 0; n < 400; n++) begin
            // small windows churn neighbour counts, some crossing the wrap
            if (n % 50 == 0) begin
               base_r = $urandom_range(0, 31);
               base_c = $urandom_range(0, 31);
               clustered = ($urandom_range(0, 2) != 0);
            end
            if (clustered) begin
               row = 5'(base_r + $urandom_range(0, 3));
               col = 5'(base_c + $urandom_range(0, 3));
            end else begin
               row = 5'($urandom);
               col = 5'($urandom);
            end
            kind = ($urandom_range(0, 9) < 7) ? REQ_TRIAL : REQ_LOAD;
            send_item(kind, row, col, 1'($urandom), 16'($urandom));
            if (n == 200 && phase % 2 == 0) drain_results();
         end
      end
   endtask

   // Receiver: always ready, random stalls, or long stalls
   always @(negedge clock) begin
      rx_count++;
      if (rx_count % 300 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_stall_left > 0)
         rx_stall_left--;
      else if (rx_mode == 2 && $urandom_range(0, 9) == 0)
         rx_stall_left = $urandom_range(1, 24);
      case (rx_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 2) != 0);
         default: rsp_if.ready <= (rx_stall_left == 0);
      endcase
   end

   // Result check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_spin_results.size() == 0) begin
            report_mismatch("unexpected result beat", 64'h0, 64'h1);
         end else begin
            spin_want = pending_spin_results.pop_front();
            if (rsp_if.flip_taken !== spin_want.flip_taken)
               report_mismatch("flip_taken", 64'(spin_want.flip_taken), 64'(rsp_if.flip_taken));
            if (rsp_if.spin_now !== spin_want.spin_now)
               report_mismatch("spin_now", 64'(spin_want.spin_now), 64'(rsp_if.spin_now));
            if (rsp_if.magnetization_now !== spin_want.magnetization_now)
               report_mismatch("magnetization_now", 64'(spin_want.magnetization_now),
                               64'(rsp_if.magnetization_now));
            if (rsp_if.energy_now !== spin_want.energy_now)
               report_mismatch("energy_now", 64'(spin_want.energy_now), 64'(rsp_if.energy_now));
            if (rsp_if.energy_change !== spin_want.energy_change)
               report_mismatch("energy_change", 64'(spin_want.energy_change),
                               64'(rsp_if.energy_change));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("ising_metropolis_spin_update_top_test NOT OK");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.req_type        = REQ_LOAD;
      req_if.site_row        = '0;
      req_if.site_col        = '0;
      req_if.load_spin_up    = 1'b0;
      req_if.random_fraction = '0;
      rsp_if.ready           = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;

      // predicted state after reset
      foreach (lattice[r, c]) lattice[r][c] = 1'b1;
      mag_total          = SITES;
      energy_total       = longint'(ENERGY_RESET);
      cfg_now.coupling_j = 16'(RESET_J);
      cfg_now.field_h    = 16'(RESET_H);
      cfg_now.tab_low    = '0;
      cfg_now.tab_mid    = '0;
      cfg_now.tab_high   = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_lattice();
      test_spin_loads();
      test_acceptance_threshold();
      test_coupling_extremes();
      test_register_access();
      test_random_trials();
      drain_results();
      repeat (16) @(posedge clock);

      if (errors == 0 && pending_spin_results.size() == 0) begin
         $display("ising_metropolis_spin_update_top_test OK");
      end else begin
         $display("ising_metropolis_spin_update_top_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- ising_metropolis_spin_update_top.f -----
design/imsu_pkg.sv
design/imsu_req_if.sv
design/imsu_rsp_if.sv
design/imsu_csr.sv
design/imsu_ctrl.sv
design/imsu_datapath.sv
design/ising_metropolis_spin_update_top.sv
tb/ising_metropolis_spin_update_top_test.sv
